// ===== src/hls8_pkg.sv =====
// Package for the half-float linear to 8-bit sRGB converter: widths, types,
// binary16 decode helpers and the elaboration-time table of code thresholds.
// Depends on nothing.
`default_nettype none

package hls8_pkg;

   localparam int HalfW   = 16;
   localparam int CodeW   = 8;
   localparam int MagW    = 14;
   localparam int FixW    = 25;
   localparam int BigW    = 384;
   localparam int NumCh   = 3;
   localparam int CodeMax = (1 << CodeW) - 1;

   typedef logic [HalfW-1:0] half_type;
   typedef logic [MagW-1:0]  mag_type;
   typedef logic [CodeW-1:0] code_type;
   typedef mag_type [CodeMax:0] thr_tbl_type;
   typedef logic [BigW-1:0]  big_type;

   // Magnitude of the value one in binary16, and a threshold that no clamped
   // magnitude reaches.
   localparam mag_type OneMag  = MagW'(16'h3C00);
   localparam mag_type ThrNone = MagW'(16'h3C01);

   // Clamps a binary16 pattern to 0..1; NaN and negative values read as zero.
   function automatic mag_type clamp_mag(half_type raw);
      mag_type r;
      r = '0;
      if (raw[15] == 1'b1 || (raw[14:10] == 5'h1F && raw[9:0] != '0)) begin
         r = '0;
      end else if (raw[14:0] > 15'(OneMag)) begin
         r = OneMag;
      end else begin
         r = raw[MagW-1:0];
      end
      return r;
   endfunction

   // A pixel is covered when its coverage alpha is a strictly positive number.
   function automatic logic cover_ok(half_type raw);
      return raw[15] == 1'b0 && !(raw[14:10] == 5'h1F && raw[9:0] != '0) &&
             raw[14:0] != '0;
   endfunction

   // Clamped magnitude as an integer count of 2^-24.
   function automatic logic [FixW-1:0] mag_to_fix(mag_type h);
      logic [FixW-1:0] r;
      r = '0;
      if (h[13:10] == 4'd0) begin
         r = FixW'(h[9:0]);
      end else begin
         r = FixW'({1'b1, h[9:0]}) << (h[13:10] - 4'd1);
      end
      return r;
   endfunction

   function automatic logic lin_region(mag_type h);
      return 64'(mag_to_fix(h)) * 64'd10000000 <= 64'd31308 * 64'd16777216;
   endfunction

   function automatic logic lin_reaches(mag_type h, int k);
      return 64'd32946 * 64'(mag_to_fix(h)) + 64'd5 * 64'd16777216 >=
             64'(k) * 64'd10 * 64'd16777216;
   endfunction

   function automatic logic curve_reaches(mag_type h, big_type p12, big_type rhs);
      big_type lhs;
      lhs = p12;
      for (int i = 0; i < 5; i++) begin
         lhs = lhs * BigW'(mag_to_fix(h));
      end
      return lhs >= rhs;
   endfunction

   // For each code k, the smallest clamped magnitude whose code is at least k.
   // The code is nondecreasing in the magnitude, so a compare against this
   // table decides one bit of the code.
   function automatic thr_tbl_type build_thr();
      thr_tbl_type t;
      big_type     p12;
      big_type     rhs;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] mid;
      logic        ok;
      p12 = BigW'(1);
      for (int i = 0; i < 12; i++) begin
         p12 = p12 * BigW'(269025);
      end
      t[0] = '0;
      for (int k = 1; k <= CodeMax; k++) begin
         rhs = BigW'(1);
         for (int i = 0; i < 12; i++) begin
            rhs = rhs * BigW'(1000 * k + 13525);
         end
         rhs = rhs << 120;
         lo = '0;
         hi = 16'(ThrNone);
         for (int it = 0; it < 16; it++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               if (lin_region(mid[MagW-1:0])) begin
                  ok = lin_reaches(mid[MagW-1:0], k);
               end else begin
                  ok = curve_reaches(mid[MagW-1:0], p12, rhs);
               end
               if (ok) begin
                  hi = mid;
               end else begin
                  lo = mid + 16'd1;
               end
            end
         end
         t[k] = lo[MagW-1:0];
      end
      return t;
   endfunction

   localparam thr_tbl_type ThrTable = build_thr();

endpackage

`default_nettype wire

// ===== src/hls8_if.sv =====
// Valid/ready channel interfaces for the pixel beats entering and leaving
// the converter. Depends on hls8_pkg.
`default_nettype none

interface hls8_req_if import hls8_pkg::*; ();
   logic     valid;
   logic     ready;
   half_type lin_red;
   half_type lin_green;
   half_type lin_blue;
   half_type cover_alpha;
   logic     last_in;

   modport source (output valid, lin_red, lin_green, lin_blue, cover_alpha, last_in,
                   input ready);
   modport sink (input valid, lin_red, lin_green, lin_blue, cover_alpha, last_in,
                 output ready);
endinterface

interface hls8_rsp_if import hls8_pkg::*; ();
   logic     valid;
   logic     ready;
   code_type out_red;
   code_type out_green;
   code_type out_blue;
   code_type out_alpha;
   logic     last_out;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, last_out,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, last_out,
                 output ready);
endinterface

`default_nettype wire

// ===== src/half_linear_to_srgb8_cutout.sv =====
// One beat is accepted every cycle while the result side takes beats.
// An input register clamps each channel; eight search stages then settle one
// code bit each against the threshold table, with valid bits alongside.
// A stalled result beat holds the whole pipeline in place.
// Synchronous reset clears the valid bits only. Depends on hls8_pkg, hls8_if.
`default_nettype none

module half_linear_to_srgb8_cutout import hls8_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   hls8_req_if.sink   req_pix,
   hls8_rsp_if.source rsp_pix
);

   localparam int NumStg = CodeW + 1;
   localparam int LastStg = NumStg - 1;

   logic [NumStg-1:0] vld_ff;
   logic [NumStg-1:0] vld_in;
   logic [NumStg-1:0] cov_ff;
   logic [NumStg-1:0] cov_in;
   logic [NumStg-1:0] last_ff;
   logic [NumStg-1:0] last_in;
   mag_type           mag_ff [NumStg][NumCh];
   mag_type           mag_in [NumStg][NumCh];
   code_type          k_ff [NumStg][NumCh];
   code_type          k_in [NumStg][NumCh];
   half_type          chan_raw [NumCh];
   logic              advance;

   assign advance = !vld_ff[LastStg] || rsp_pix.ready;
   assign req_pix.ready = advance;

   assign chan_raw[0] = req_pix.lin_red;
   assign chan_raw[1] = req_pix.lin_green;
   assign chan_raw[2] = req_pix.lin_blue;

   always_comb begin
      code_type cand;
      int       b;
      cand = '0;
      b = 0;
      vld_in[0]  = req_pix.valid;
      cov_in[0]  = cover_ok(req_pix.cover_alpha);
      last_in[0] = req_pix.last_in;
      for (int c = 0; c < NumCh; c++) begin
         // An uncovered pixel enters as magnitude zero, which encodes as zero.
         mag_in[0][c] = cov_in[0] ? clamp_mag(chan_raw[c]) : '0;
         k_in[0][c]   = '0;
      end
      for (int s = 1; s < NumStg; s++) begin
         b = CodeW - s;
         vld_in[s]  = vld_ff[s-1];
         cov_in[s]  = cov_ff[s-1];
         last_in[s] = last_ff[s-1];
         for (int c = 0; c < NumCh; c++) begin
            cand = k_ff[s-1][c] | (code_type'(1) << b);
            mag_in[s][c] = mag_ff[s-1][c];
            k_in[s][c]   = (mag_ff[s-1][c] >= ThrTable[cand]) ? cand : k_ff[s-1][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cov_ff  <= cov_in;
         last_ff <= last_in;
         mag_ff  <= mag_in;
         k_ff    <= k_in;
      end
   end

   assign rsp_pix.valid     = vld_ff[LastStg];
   assign rsp_pix.out_red   = k_ff[LastStg][0];
   assign rsp_pix.out_green = k_ff[LastStg][1];
   assign rsp_pix.out_blue  = k_ff[LastStg][2];
   assign rsp_pix.out_alpha = {CodeW{cov_ff[LastStg]}};
   assign rsp_pix.last_out  = last_ff[LastStg];

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_pix.valid)
      else $error("result beat valid right after reset");

   a_uncovered_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_pix.valid && !cov_ff[LastStg] |->
         rsp_pix.out_red == '0 && rsp_pix.out_green == '0 && rsp_pix.out_blue == '0)
      else $error("uncovered pixel gave a nonzero color code");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_pix.valid && !rsp_pix.ready |-> !req_pix.ready)
      else $error("input accepted while the result beat is stalled");

   a_valid_shift: assert property (@(posedge clock) disable iff (reset)
      advance |=> vld_ff[LastStg] == $past(vld_ff[LastStg-1]))
      else $error("valid bit lost or repeated in the pipeline");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ===== sim/half_linear_to_srgb8_cutout_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for half_linear_to_srgb8_cutout: drives pixel beats with
// random gaps and result stalls, and checks each result against exact sRGB codes.
// Depends on hls8_pkg, hls8_if and the converter RTL.

module half_linear_to_srgb8_cutout_tb;
   import hls8_pkg::*;

   localparam int RandomPixels = 1350;
   localparam int CycleLimit   = 500000;
   localparam int SettleCycles = 30;

   typedef struct packed {
      half_type red;
      half_type green;
      half_type blue;
      half_type coverage;
      logic     last;
   } lin_pixel_type;

   typedef struct packed {
      code_type red;
      code_type green;
      code_type blue;
      code_type alpha;
      logic     last;
   } srgb_pixel_type;

   class srgb_pixel_board_type;
      srgb_pixel_type pending_codes[$];
      int             errors;
      int             noted;
      big_type        gain12;
      big_type        code_bound[CodeMax:1];

      function new();
         big_type b;
         errors = 0;
         noted  = 0;
         gain12 = big_type'(1);
         repeat (12) gain12 = gain12 * big_type'(269025);
         for (int k = 1; k <= CodeMax; k++) begin
            b = big_type'(1);
            repeat (12) b = b * big_type'(1000 * k + 13525);
            code_bound[k] = b << 120;
         end
      endfunction

      function logic [FixW-1:0] clamp_fix(half_type h);
         if (h[15] || (h[14:10] == 5'h1F && h[9:0] != 10'd0)) begin
            return '0;
         end
         if (h[14:0] > 15'h3C00) begin
            return FixW'(1) << 24;
         end
         if (h[14:10] == 5'd0) begin
            return FixW'(h[9:0]);
         end
         return FixW'({1'b1, h[9:0]}) << (h[14:10] - 5'd1);
      endfunction

      function code_type encode_srgb(half_type h);
         logic [FixW-1:0] m;
         logic [63:0]     lin_code;
         big_type         lhs;
         code_type        k;
         m = clamp_fix(h);
         if (64'(m) * 64'd10000000 <= 64'd31308 * 64'd16777216) begin
            lin_code = (64'd32946 * 64'(m) + 64'd5 * 64'd16777216) /
                       (64'd10 * 64'd16777216);
            return code_type'(lin_code);
         end
         lhs = gain12;
         repeat (5) lhs = lhs * big_type'(m);
         k = '0;
         for (int i = 1; i <= CodeMax; i++) begin
            if (lhs >= code_bound[i]) begin
               k = code_type'(i);
            end
         end
         return k;
      endfunction

      function void note_pixel(lin_pixel_type p);
         srgb_pixel_type e;
         logic           hit;
         hit = !p.coverage[15] &&
               !(p.coverage[14:10] == 5'h1F && p.coverage[9:0] != 10'd0) &&
               p.coverage[14:0] != 15'd0;
         e.red   = hit ? encode_srgb(p.red) : '0;
         e.green = hit ? encode_srgb(p.green) : '0;
         e.blue  = hit ? encode_srgb(p.blue) : '0;
         e.alpha = hit ? code_type'(CodeMax) : '0;
         e.last  = p.last;
         pending_codes.push_back(e);
         noted++;
      endfunction

      function void check_pixel(srgb_pixel_type got);
         srgb_pixel_type e;
         if (pending_codes.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("Unexpected result beat: r=%0d g=%0d b=%0d a=%0d last=%0b",
                        got.red, got.green, got.blue, got.alpha, got.last);
            end
            return;
         end
         e = pending_codes.pop_front();
         if (got.red !== e.red || got.green !== e.green || got.blue !== e.blue ||
             got.alpha !== e.alpha || got.last !== e.last) begin
            errors++;
            if (errors <= 10) begin
               $display("Result mismatch: expected r=%0d g=%0d b=%0d a=%0d last=%0b",
                        e.red, e.green, e.blue, e.alpha, e.last);
               $display("                 actual   r=%0d g=%0d b=%0d a=%0d last=%0b",
                        got.red, got.green, got.blue, got.alpha, got.last);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet_run;
   int   sent_count;
   int   cycle_count;

   srgb_pixel_board_type board;

   half_type special_halves[18] = '{
      16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h0400, 16'h1A69,
      16'h1A6A, 16'h3800, 16'h3BFF, 16'h3C00, 16'h3C01, 16'h7BFF,
      16'h7C00, 16'hFC00, 16'h7E00, 16'hFE00, 16'h7C01, 16'hBC00
   };

   half_type cover_cases[7] = '{
      16'h0000, 16'h8000, 16'h0001, 16'h7C00, 16'h7E00, 16'hBC00, 16'h7BFF
   };

   hls8_req_if req_pix ();
   hls8_rsp_if rsp_pix ();

   half_linear_to_srgb8_cutout i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_pix (req_pix),
      .rsp_pix (rsp_pix)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic half_type rand_channel();
      int pick;
      pick = $urandom_range(0, 9);
      unique case (pick)
         0, 1, 2, 3: return half_type'($urandom_range(0, 16'h3C00));
         4:          return half_type'($urandom_range(16'h1A60, 16'h1A70));
         5:          return half_type'($urandom_range(16'h3B00, 16'h3C08));
         6, 7:       return half_type'($urandom_range(0, 16'hFFFF));
         default:    return special_halves[$urandom_range(0, 17)];
      endcase
   endfunction

   function automatic half_type rand_cover();
      int pick;
      pick = $urandom_range(0, 9);
      unique case (pick)
         7:       return half_type'($urandom_range(0, 16'hFFFF));
         8, 9:    return special_halves[$urandom_range(0, 17)];
         default: return half_type'($urandom_range(1, 16'h7BFF));
      endcase
   endfunction

   task automatic send_pixel(input lin_pixel_type p);
      int gap;
      gap = quiet_run ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_pix.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_pix.valid       <= 1'b1;
      req_pix.lin_red     <= p.red;
      req_pix.lin_green   <= p.green;
      req_pix.lin_blue    <= p.blue;
      req_pix.cover_alpha <= p.coverage;
      req_pix.last_in     <= p.last;
      do @(posedge clock); while (req_pix.ready !== 1'b1);
      sent_count++;
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && req_pix.valid === 1'b1 && req_pix.ready === 1'b1) begin
         board.note_pixel(lin_pixel_type'{req_pix.lin_red, req_pix.lin_green,
                                          req_pix.lin_blue, req_pix.cover_alpha,
                                          req_pix.last_in});
      end
      if (reset === 1'b0 && rsp_pix.valid === 1'b1 && rsp_pix.ready === 1'b1) begin
         board.check_pixel(srgb_pixel_type'{rsp_pix.out_red, rsp_pix.out_green,
                                            rsp_pix.out_blue, rsp_pix.out_alpha,
                                            rsp_pix.last_out});
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : rsp_side
      int stall;
      rsp_pix.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = quiet_run ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_pix.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pix.ready <= 1'b1;
         do @(posedge clock); while (rsp_pix.valid !== 1'b1);
      end
   end

   initial begin : req_side
      lin_pixel_type p;
      board       = new();
      quiet_run   = 1'b0;
      sent_count  = 0;
      cycle_count = 0;
      reset               <= 1'b1;
      req_pix.valid       <= 1'b0;
      req_pix.lin_red     <= '0;
      req_pix.lin_green   <= '0;
      req_pix.lin_blue    <= '0;
      req_pix.cover_alpha <= '0;
      req_pix.last_in     <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Clamp, NaN, subnormal and segment-boundary values on every channel.
      for (int i = 0; i < 18; i++) begin
         p.red      = special_halves[i];
         p.green    = special_halves[(i + 7) % 18];
         p.blue     = special_halves[(i + 13) % 18];
         p.coverage = 16'h3C00;
         p.last     = i[0];
         send_pixel(p);
      end
      // Coverage cutout cases with arbitrary color.
      for (int i = 0; i < 7; i++) begin
         p.red      = rand_channel();
         p.green    = rand_channel();
         p.blue     = rand_channel();
         p.coverage = cover_cases[i];
         p.last     = ~i[0];
         send_pixel(p);
      end

      for (int i = 0; i < RandomPixels; i++) begin
         if (i % 150 == 0) begin
            quiet_run = ($urandom_range(0, 3) == 0);
         end
         p.red      = rand_channel();
         p.green    = rand_channel();
         p.blue     = rand_channel();
         p.coverage = rand_cover();
         p.last     = ($urandom_range(0, 15) == 0);
         send_pixel(p);
      end
      req_pix.valid <= 1'b0;
      quiet_run = 1'b0;

      while (board.noted != sent_count || board.pending_codes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);

      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
